// File: src/oaht_pkg.sv
// Shared types, codes and defaults for the open-addressing hash table.
package oaht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PROBE_SHIFT = 5;
  localparam int KEY_W       = 32;
  localparam int MAX_FILL_W  = 6;
  localparam int LIVE_W      = 7;
  localparam logic [MAX_FILL_W-1:0] MAX_FILL_RESET = 6'd42;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_LIVE    = 2'd1,
    SLOT_DELETED = 2'd2,
    SLOT_UNUSED  = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    RESP_PRESENT = 2'd0,
    RESP_ABSENT  = 2'd1,
    RESP_FULL    = 2'd2,
    RESP_SPARE   = 2'd3
  } resp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] hash;
    logic [KEY_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic is_empty;
    logic is_match;
    logic is_free;
  } probe_res_t;

endpackage

// File: src/open_addressing_hash_table_core.sv
// Top level: request sequencer, counters and result register of the hash table.
//
// Open-addressing key/value table of TABLE_DEPTH slots with perturbed probing.
// Each request transaction (lookup, insert/overwrite or delete) probes one slot
// per cycle through the single read port of the slot store, starting at
// key_hash masked to the table size; the next slot is 5*i + perturb + 1 with
// perturb shifted right by PROBE_SHIFT on every step but the first. A request
// reads its home slot on acceptance, then one further slot per probe, and then
// commits; a new request can be accepted the cycle after the commit, and the
// commit waits while an earlier result stalls in the output register. At most
// TABLE_DEPTH + 33 probes are made. in_stall stays high while a request is in
// flight, so one request is worked at a time, but a new one may be accepted
// while the previous result still waits in the output register. After reset
// the slot states are cleared by a sweep of the TABLE_DEPTH slots during which
// in_stall is high; max_fill writes are taken at any time (cfg_ready is always
// high) but must only be made while the table is idle. Inserts that would
// occupy a fresh empty slot are refused once the fill count reaches max_fill
// (capped at TABLE_DEPTH - 1); deleted slots are reused but never purged.
module open_addressing_hash_table_core #(
  parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH,
  parameter int PROBE_SHIFT = oaht_pkg::PROBE_SHIFT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic [oaht_pkg::KEY_W-1:0]           key,
  input  logic [oaht_pkg::KEY_W-1:0]           key_hash,
  input  logic [oaht_pkg::KEY_W-1:0]           new_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [oaht_pkg::KEY_W-1:0]           value_out,
  output logic [oaht_pkg::LIVE_W-1:0]          live_entries,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [oaht_pkg::MAX_FILL_W-1:0]      max_fill
);

  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = $clog2(TABLE_DEPTH + 1);
  localparam int PROBE_LIMIT = TABLE_DEPTH + 33;
  localparam int PW          = $clog2(PROBE_LIMIT);
  localparam int MW          = (CW > oaht_pkg::MAX_FILL_W) ? CW : oaht_pkg::MAX_FILL_W;
  localparam logic [AW-1:0] SLOT_MASK  = AW'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_COMMIT
  } state_t;

  state_t state;

  // request held for the whole transaction
  oaht_pkg::cmd_t                cmd_r;
  logic [oaht_pkg::KEY_W-1:0]    key_r;
  logic [oaht_pkg::KEY_W-1:0]    hash_r;
  logic [oaht_pkg::KEY_W-1:0]    value_r;

  // probe walk
  logic [AW-1:0]                 idx;
  logic [oaht_pkg::KEY_W-1:0]    perturb;
  logic [PW-1:0]                 probe_n;
  logic                          have_free;
  logic [AW-1:0]                 free_at;

  // probe outcome
  logic                          found;
  logic                          have_slot;
  logic                          target_empty;
  logic [AW-1:0]                 target;
  logic [oaht_pkg::KEY_W-1:0]    found_value;

  logic [CW-1:0]                 live_count;
  logic [CW-1:0]                 fill_count;
  logic [oaht_pkg::MAX_FILL_W-1:0] max_fill_r;
  logic [AW-1:0]                 clr_addr;

  // store and probe unit wiring
  logic [AW-1:0]                 rd_addr;
  oaht_pkg::slot_state_t         rd_state;
  oaht_pkg::entry_t              rd_entry;
  logic                          st_we;
  logic [AW-1:0]                 st_addr;
  oaht_pkg::slot_state_t         st_wdata;
  logic                          kv_we;
  oaht_pkg::entry_t              kv_wdata;

  oaht_pkg::probe_res_t          pres;
  logic [AW-1:0]                 idx_next;
  logic [oaht_pkg::KEY_W-1:0]    perturb_next;
  logic                          first;

  // commit decision
  logic                          commit_go;
  logic [CW-1:0]                 fill_limit;
  oaht_pkg::resp_t               resp;
  logic [oaht_pkg::KEY_W-1:0]    resp_value;
  logic [CW-1:0]                 live_count_next;
  logic [CW-1:0]                 fill_count_next;
  logic                          in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign first     = (probe_n == '0);
  assign commit_go = (state == S_COMMIT) && !(out_valid && out_stall);

  // home slot is read on acceptance, then each step reads the next index
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = key_hash[AW-1:0];
      S_PROBE: rd_addr = idx_next;
      default: rd_addr = idx;
    endcase
  end

  oaht_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .st_we    (st_we),
    .st_addr  (st_addr),
    .st_wdata (st_wdata),
    .kv_we    (kv_we),
    .kv_addr  (target),
    .kv_wdata (kv_wdata),
    .rd_state (rd_state),
    .rd_entry (rd_entry)
  );

  oaht_probe_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PROBE_SHIFT (PROBE_SHIFT)
  ) u_probe (
    .idx          (idx),
    .perturb      (perturb),
    .first        (first),
    .slot_state   (rd_state),
    .entry        (rd_entry),
    .key          (key_r),
    .key_hash     (hash_r),
    .res          (pres),
    .idx_next     (idx_next),
    .perturb_next (perturb_next)
  );

  // fill limit is max_fill capped so one slot always stays empty
  always_comb begin
    if (MW'(max_fill_r) > MW'(SLOT_MASK)) begin
      fill_limit = CW'(SLOT_MASK);
    end else begin
      fill_limit = CW'(max_fill_r);
    end
  end

  assign kv_wdata.key   = key_r;
  assign kv_wdata.hash  = hash_r;
  assign kv_wdata.value = value_r;

  // what the clear sweep and the commit cycle do to the store, the counters and the result
  always_comb begin
    resp            = oaht_pkg::RESP_ABSENT;
    resp_value      = '0;
    live_count_next = live_count;
    fill_count_next = fill_count;
    st_we           = 1'b0;
    st_addr         = target;
    st_wdata        = oaht_pkg::SLOT_LIVE;
    kv_we           = 1'b0;

    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_addr  = clr_addr;
      st_wdata = oaht_pkg::SLOT_EMPTY;
    end else if (commit_go) begin
      unique case (cmd_r)
        oaht_pkg::CMD_INSERT: begin
          if (found) begin
            kv_we = 1'b1;
            resp  = oaht_pkg::RESP_PRESENT;
          end else if (!have_slot) begin
            resp = oaht_pkg::RESP_FULL;
          end else if (target_empty && (fill_count >= fill_limit)) begin
            resp = oaht_pkg::RESP_FULL;
          end else begin
            st_we           = 1'b1;
            kv_we           = 1'b1;
            live_count_next = live_count + CW'(1);
            if (target_empty) begin
              fill_count_next = fill_count + CW'(1);
            end
          end
        end
        oaht_pkg::CMD_DELETE: begin
          if (found) begin
            st_we      = 1'b1;
            st_wdata   = oaht_pkg::SLOT_DELETED;
            resp       = oaht_pkg::RESP_PRESENT;
            resp_value = found_value;
            if (live_count != '0) begin
              live_count_next = live_count - CW'(1);
            end
          end
        end
        default: begin
          // lookup, and the spare code behaves the same
          if (found) begin
            resp       = oaht_pkg::RESP_PRESENT;
            resp_value = found_value;
          end
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      live_count   <= '0;
      fill_count   <= '0;
      max_fill_r   <= oaht_pkg::MAX_FILL_RESET;
      out_valid    <= 1'b0;
      probe_n      <= '0;
      have_free    <= 1'b0;
      found        <= 1'b0;
      have_slot    <= 1'b0;
      target_empty <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_fill_r <= max_fill;
      end
      if (out_valid && !out_stall && !commit_go) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == SLOT_MASK) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_accept) begin
            cmd_r     <= oaht_pkg::cmd_t'(cmd);
            key_r     <= key;
            hash_r    <= key_hash;
            value_r   <= new_value;
            idx       <= key_hash[AW-1:0];
            perturb   <= key_hash;
            probe_n   <= '0;
            have_free <= 1'b0;
            state     <= S_PROBE;
          end
        end

        S_PROBE: begin
          if (pres.is_empty) begin
            found        <= 1'b0;
            have_slot    <= 1'b1;
            target       <= have_free ? free_at : idx;
            target_empty <= !have_free;
            state        <= S_COMMIT;
          end else if (pres.is_match) begin
            found       <= 1'b1;
            have_slot   <= 1'b1;
            target      <= idx;
            found_value <= rd_entry.value;
            state       <= S_COMMIT;
          end else begin
            // first deleted slot on the path is kept for reuse
            if (pres.is_free && !have_free) begin
              have_free <= 1'b1;
              free_at   <= idx;
            end
            if (probe_n == LAST_PROBE) begin
              // probe bound reached without an empty slot
              found        <= 1'b0;
              have_slot    <= have_free || pres.is_free;
              target       <= have_free ? free_at : idx;
              target_empty <= 1'b0;
              state        <= S_COMMIT;
            end else begin
              idx     <= idx_next;
              perturb <= perturb_next;
              probe_n <= probe_n + PW'(1);
            end
          end
        end

        S_COMMIT: begin
          if (commit_go) begin
            live_count   <= live_count_next;
            fill_count   <= fill_count_next;
            status       <= resp;
            value_out    <= resp_value;
            live_entries <= oaht_pkg::LIVE_W'(live_count_next);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // live keys are a subset of occupied slots
  a_live_le_fill: assert property (@(posedge clk) disable iff (rst)
    live_count <= fill_count)
    else $error("live count exceeds fill count");

  // at least one slot always stays empty
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(SLOT_MASK))
    else $error("fill count passed the table limit");

  // a commit always lands a result in the output register
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit_go |=> out_valid && (state == S_IDLE))
    else $error("commit did not produce a result");

  // the walk never runs past the probe bound
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (probe_n <= LAST_PROBE))
    else $error("probe counter beyond bound");

endmodule

// File: src/oaht_store.sv
// Slot store: state memory and key/hash/value memory, one read port each.
module oaht_store #(
  parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  logic                             st_we,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   st_addr,
  input  oaht_pkg::slot_state_t            st_wdata,
  input  logic                             kv_we,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   kv_addr,
  input  oaht_pkg::entry_t                 kv_wdata,
  output oaht_pkg::slot_state_t            rd_state,
  output oaht_pkg::entry_t                 rd_entry
);

  oaht_pkg::slot_state_t st_mem [TABLE_DEPTH];
  oaht_pkg::entry_t      kv_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= st_wdata;
    end
    rd_state <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      kv_mem[kv_addr] <= kv_wdata;
    end
    rd_entry <= kv_mem[rd_addr];
  end

endmodule

// File: src/oaht_probe_unit.sv
// Probe step: classifies the slot just read and forms the next probe index.
module oaht_probe_unit #(
  parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH,
  parameter int PROBE_SHIFT = oaht_pkg::PROBE_SHIFT
) (
  input  logic [$clog2(TABLE_DEPTH)-1:0]   idx,
  input  logic [oaht_pkg::KEY_W-1:0]       perturb,
  input  logic                             first,
  input  oaht_pkg::slot_state_t            slot_state,
  input  oaht_pkg::entry_t                 entry,
  input  logic [oaht_pkg::KEY_W-1:0]       key,
  input  logic [oaht_pkg::KEY_W-1:0]       key_hash,
  output oaht_pkg::probe_res_t             res,
  output logic [$clog2(TABLE_DEPTH)-1:0]   idx_next,
  output logic [oaht_pkg::KEY_W-1:0]       perturb_next
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [AW-1:0] five_i;

  // perturb is only shifted from the second step on
  assign perturb_next = first ? perturb : (perturb >> PROBE_SHIFT);
  assign five_i       = AW'({idx, 2'b00}) + idx;
  assign idx_next     = five_i + perturb_next[AW-1:0] + AW'(1);

  assign res.is_empty = (slot_state == oaht_pkg::SLOT_EMPTY);
  assign res.is_match = (slot_state == oaht_pkg::SLOT_LIVE) && (entry.key == key) &&
                        (first || (entry.hash == key_hash));
  assign res.is_free  = (slot_state != oaht_pkg::SLOT_EMPTY) &&
                        (slot_state != oaht_pkg::SLOT_LIVE);

endmodule

// File: tb/open_addressing_hash_table_core_tb.sv
// Self-checking bench for the open-addressing hash table core: directed rows, then random traffic.
module open_addressing_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH;
  localparam int KEY_W       = oaht_pkg::KEY_W;
  localparam int LIVE_W      = oaht_pkg::LIVE_W;
  localparam int MAX_FILL_W  = oaht_pkg::MAX_FILL_W;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PROBE_MAX   = TABLE_DEPTH + 33;
  localparam int KEY_POOL    = 40;
  localparam int N_CHUNKS    = 5;
  localparam int CHUNK_ITEMS = 230;
  localparam int N_DIRECTED  = 21;
  localparam int CYCLE_LIMIT = 1000000;

  // one response as seen on the result channel
  typedef struct packed {
    logic [1:0]        st;
    logic [KEY_W-1:0]  vo;
    logic [LIVE_W-1:0] le;
  } table_resp_t;

  // directed row: request, plus a hand-written response where chk is set
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  k;
    logic [KEY_W-1:0]  h;
    logic [KEY_W-1:0]  v;
    logic              chk;
    logic [1:0]        st;
    logic [KEY_W-1:0]  vo;
    logic [LIVE_W-1:0] le;
  } req_row_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            cmd;
  logic [KEY_W-1:0]      key;
  logic [KEY_W-1:0]      key_hash;
  logic [KEY_W-1:0]      new_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [KEY_W-1:0]      value_out;
  logic [LIVE_W-1:0]     live_entries;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MAX_FILL_W-1:0] max_fill;

  // shadow copy of the table
  oaht_pkg::slot_state_t shadow_state [TABLE_DEPTH];
  logic [KEY_W-1:0]      shadow_key   [TABLE_DEPTH];
  logic [KEY_W-1:0]      shadow_hash  [TABLE_DEPTH];
  logic [KEY_W-1:0]      shadow_val   [TABLE_DEPTH];
  int unsigned           shadow_live;
  int unsigned           shadow_fill;
  logic [MAX_FILL_W-1:0] fill_limit;

  table_resp_t           pending_resps [$];
  req_row_t              dir_rows [N_DIRECTED];
  logic [KEY_W-1:0]      pool_key  [KEY_POOL];
  logic [KEY_W-1:0]      pool_hash [KEY_POOL];

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    mismatches    = 0;
  int                    cycles        = 0;
  int                    op_count [4]  = '{0, 0, 0, 0};
  int                    full_count    = 0;

  open_addressing_hash_table_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .key          (key),
    .key_hash     (key_hash),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .value_out    (value_out),
    .live_entries (live_entries),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .max_fill     (max_fill)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost response ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               pending_resps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Probe and update the shadow table for one request; returns the response it
  // should give. Home slot matches on key alone, later probes need key and hash.
  function automatic table_resp_t apply_request(input logic [1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [KEY_W-1:0] h,
                                                input logic [KEY_W-1:0] v);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] slot_at;
    logic [IDX_W-1:0] free_at;
    logic [KEY_W-1:0] pert;
    logic [KEY_W-1:0] step;
    bit               found;
    bit               have_slot;
    bit               have_free;
    bit               done;
    bit               take_empty;
    int unsigned      cap;
    int               n;
    table_resp_t      r;
    idx       = h[IDX_W-1:0];
    pert      = h;
    slot_at   = '0;
    free_at   = '0;
    found     = 1'b0;
    have_slot = 1'b0;
    have_free = 1'b0;
    done      = 1'b0;
    for (n = 0; n < PROBE_MAX && !done; n++) begin
      if (shadow_state[idx] == oaht_pkg::SLOT_EMPTY) begin
        have_slot = 1'b1;
        slot_at   = have_free ? free_at : idx;
        done      = 1'b1;
      end else if (shadow_state[idx] == oaht_pkg::SLOT_LIVE && shadow_key[idx] == k &&
                   (n == 0 || shadow_hash[idx] == h)) begin
        found   = 1'b1;
        slot_at = idx;
        done    = 1'b1;
      end else begin
        // first tombstone seen is kept for reuse
        if (shadow_state[idx] != oaht_pkg::SLOT_LIVE && !have_free) begin
          have_free = 1'b1;
          free_at   = idx;
        end
        if (n > 0)
          pert = pert >> oaht_pkg::PROBE_SHIFT;
        step = idx * 32'd5 + pert + 32'd1;
        idx  = step[IDX_W-1:0];
      end
    end
    // probe bound hit with no empty slot: fall back on a tombstone if any
    if (!done && have_free) begin
      have_slot = 1'b1;
      slot_at   = free_at;
    end

    r.st = oaht_pkg::RESP_ABSENT;
    r.vo = '0;
    case (op)
      oaht_pkg::CMD_INSERT: begin
        if (found) begin
          shadow_val[slot_at]  = v;
          shadow_hash[slot_at] = h;
          r.st = oaht_pkg::RESP_PRESENT;
        end else if (!have_slot) begin
          r.st = oaht_pkg::RESP_FULL;
        end else begin
          cap        = (fill_limit > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : fill_limit;
          take_empty = (shadow_state[slot_at] == oaht_pkg::SLOT_EMPTY);
          if (take_empty && shadow_fill + 1 > cap) begin
            r.st = oaht_pkg::RESP_FULL;
          end else begin
            if (take_empty)
              shadow_fill++;
            shadow_state[slot_at] = oaht_pkg::SLOT_LIVE;
            shadow_key[slot_at]   = k;
            shadow_hash[slot_at]  = h;
            shadow_val[slot_at]   = v;
            shadow_live++;
          end
        end
      end
      oaht_pkg::CMD_DELETE: begin
        if (found) begin
          r.vo = shadow_val[slot_at];
          shadow_state[slot_at] = oaht_pkg::SLOT_DELETED;
          if (shadow_live > 0)
            shadow_live--;
          r.st = oaht_pkg::RESP_PRESENT;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        if (found) begin
          r.vo = shadow_val[slot_at];
          r.st = oaht_pkg::RESP_PRESENT;
        end
      end
    endcase
    r.le = shadow_live[LIVE_W-1:0];
    return r;
  endfunction

  // Present one request, hold it until accepted, then log its response.
  // A hand-written response, where given, replaces the shadow's one.
  task automatic issue_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                               input logic [KEY_W-1:0] h, input logic [KEY_W-1:0] v,
                               input bit chk, input table_resp_t fixed);
    table_resp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    key       <= k;
    key_hash  <= h;
    new_value <= v;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    r = apply_request(op, k, h, v);
    op_count[op]++;
    if (r.st == oaht_pkg::RESP_FULL)
      full_count++;
    pending_resps.push_back(chk ? fixed : r);
  endtask

  // Drop valid and let every outstanding response come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_resps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the table idle.
  task automatic write_fill_limit(input logic [MAX_FILL_W-1:0] lim);
    cfg_valid <= 1'b1;
    max_fill  <= lim;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid  <= 1'b0;
    fill_limit  = lim;
  endtask

  // Result side: random back-pressure, and every transaction checked in order.
  always @(posedge clk) begin
    table_resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_resps.size() == 0) begin
        if (mismatches < 10)
          $display("cycle %0d: response with nothing pending (status %0d value %h live %0d)",
                   cycles, status, value_out, live_entries);
        mismatches++;
      end else begin
        e = pending_resps.pop_front();
        if (status !== e.st || value_out !== e.vo || live_entries !== e.le) begin
          if (mismatches < 10)
            $display("cycle %0d: exp status %0d value %h live %0d, got %0d %h %0d",
                     cycles, e.st, e.vo, e.le, status, value_out, live_entries);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    // fill limit and idle pattern per random chunk
    logic [MAX_FILL_W-1:0] chunk_fill [N_CHUNKS];
    int                    chunk_send [N_CHUNKS];
    int                    chunk_recv [N_CHUNKS];
    table_resp_t           fixed;
    logic [1:0]            op;
    logic [KEY_W-1:0]      k;
    logic [KEY_W-1:0]      h;
    int                    c;
    int                    i;
    int                    p;
    int                    roll;

    chunk_fill = '{6'd24, 6'd0, 6'd63, 6'd1, 6'd63};
    chunk_send = '{21, 54, 54, 0, 0};
    chunk_recv = '{54, 21, 21, 0, 0};

    // Directed rows, run with a fill limit of three. Covers field extremes,
    // home-slot match on key alone, overwrite with a fresh hash, a refused
    // insert, tombstone reuse, a later probe missing on hash, the spare code.
    dir_rows = '{
      '{oaht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd1},
      '{oaht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, oaht_pkg::RESP_PRESENT, 32'hFFFF_FFFF, 7'd1},
      '{oaht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd2},
      '{oaht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0040, 32'h0000_0000,
        1'b1, oaht_pkg::RESP_PRESENT, 32'hFFFF_FFFF, 7'd2},
      '{oaht_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5680, 32'hA5A5_A5A5,
        1'b1, oaht_pkg::RESP_PRESENT, 32'h0000_0000, 7'd2},
      '{oaht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_003F, 32'h0000_0000,
        1'b1, oaht_pkg::RESP_PRESENT, 32'h0000_0000, 7'd2},
      '{oaht_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_0000, 32'h5A5A_5A5A,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_INSERT, 32'h0000_0002, 32'h0000_0000, 32'h0000_0007,
        1'b1, oaht_pkg::RESP_FULL,    32'h0000_0000, 7'd3},
      '{oaht_pkg::CMD_DELETE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_INSERT, 32'h0000_0002, 32'h0000_0000, 32'h0000_0007,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_DELETE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_LOOKUP, 32'h0000_0002, 32'h0000_0040, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_SPARE,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_DELETE, 32'h0000_0000, 32'h1234_5680, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_INSERT, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0F0F_0F0F,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_LOOKUP, 32'hDEAD_BEEF, 32'h8000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_DELETE, 32'h0000_0002, 32'h0000_0000, 32'h0000_0000,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0},
      '{oaht_pkg::CMD_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b0, oaht_pkg::RESP_ABSENT,  32'h0000_0000, 7'd0}
    };

    // all inputs known from time zero
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = oaht_pkg::CMD_LOOKUP;
    key       = '0;
    key_hash  = '0;
    new_value = '0;
    cfg_valid = 1'b0;
    max_fill  = oaht_pkg::MAX_FILL_RESET;

    // shadow table after reset
    for (i = 0; i < TABLE_DEPTH; i++) begin
      shadow_state[i] = oaht_pkg::SLOT_EMPTY;
      shadow_key[i]   = '0;
      shadow_hash[i]  = '0;
      shadow_val[i]   = '0;
    end
    shadow_live = 0;
    shadow_fill = 0;
    fill_limit  = oaht_pkg::MAX_FILL_RESET;

    // Key pool for random traffic: half the hashes crowd the low home slots,
    // and some neighbours share a hash outright, so chains and tombstones form.
    for (i = 0; i < KEY_POOL; i++) begin
      pool_key[i]  = $urandom;
      pool_hash[i] = $urandom;
      if (i % 2 == 0)
        pool_hash[i][5:4] = 2'b00;
      if (i % 5 == 1)
        pool_hash[i] = pool_hash[i-1];
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // slot-state sweep after reset holds in_stall high
    while (in_stall)
      @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 54;
    write_fill_limit(6'd3);
    for (i = 0; i < N_DIRECTED; i++) begin
      fixed.st = dir_rows[i].st;
      fixed.vo = dir_rows[i].vo;
      fixed.le = dir_rows[i].le;
      issue_request(dir_rows[i].op, dir_rows[i].k, dir_rows[i].h, dir_rows[i].v,
                    dir_rows[i].chk, fixed);
    end

    // Random traffic in chunks; limit changes only once the table has gone idle.
    // Mostly pool keys with their own hash, some with a stray hash, some noise.
    fixed = '0;
    for (c = 0; c < N_CHUNKS; c++) begin
      drain_results();
      send_idle_pct = chunk_send[c];
      recv_idle_pct = chunk_recv[c];
      write_fill_limit(chunk_fill[c]);
      for (i = 0; i < CHUNK_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          p = $urandom_range(KEY_POOL - 1);
          k = pool_key[p];
          h = pool_hash[p];
          if ($urandom_range(9) == 0)
            h = $urandom;
        end else begin
          k = $urandom;
          h = $urandom;
        end
        roll = $urandom_range(99);
        if (roll < 45)
          op = oaht_pkg::CMD_INSERT;
        else if (roll < 70)
          op = oaht_pkg::CMD_LOOKUP;
        else if (roll < 95)
          op = oaht_pkg::CMD_DELETE;
        else
          op = oaht_pkg::CMD_SPARE;
        issue_request(op, k, h, $urandom, 1'b0, fixed);
      end
    end
    drain_results();

    $display("covered %0d lookups, %0d inserts, %0d deletes, %0d spare-code requests",
             op_count[oaht_pkg::CMD_LOOKUP], op_count[oaht_pkg::CMD_INSERT],
             op_count[oaht_pkg::CMD_DELETE], op_count[oaht_pkg::CMD_SPARE]);
    $display("%0d inserts refused as full; fill limits 0 to 63 under three idle patterns",
             full_count);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatched transactions", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
